/* rtl/core/sqpt_pkg.sv */
// Shared constants, codes and control structs for the stack/queue/priority
// trace checker. No dependencies.
package sqpt_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = ADDR_W + 1;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_C  = ADDR_W'(DEPTH - 1);

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [2:0] VERD_STACK  = 3'd0;
	localparam logic [2:0] VERD_QUEUE  = 3'd1;
	localparam logic [2:0] VERD_PRIO   = 3'd2;
	localparam logic [2:0] VERD_NONE   = 3'd3;
	localparam logic [2:0] VERD_UNSURE = 3'd4;

	typedef struct packed {
		logic clear;
		logic start;
		logic func;
	} sqpt_prio_req_t;

	typedef struct packed {
		logic busy;
		logic alive;
		logic ovf;
	} sqpt_prio_sts_t;

endpackage

/* rtl/core/sqpt_cmd_if.sv */
// Input channel of the trace checker: valid/ready plus one trace item.
// Depends on nothing.
interface sqpt_cmd_if;
	logic               valid;
	logic               ready;
	logic               first;
	logic               func;
	logic signed [31:0] value;

	modport source (output valid, output first, output func, output value, input ready);
	modport sink   (input valid, input first, input func, input value, output ready);
endinterface

/* rtl/core/sqpt_res_if.sv */
// Output channel of the trace checker: valid/ready plus the consistency flags.
// Depends on nothing.
interface sqpt_res_if;
	logic       valid;
	logic       ready;
	logic       stack_ok;
	logic       queue_ok;
	logic       prio_ok;
	logic [2:0] verdict;
	logic       overflow;

	modport source (output valid, output stack_ok, output queue_ok, output prio_ok,
		output verdict, output overflow, input ready);
	modport sink   (input valid, input stack_ok, input queue_ok, input prio_ok,
		input verdict, input overflow, output ready);
endinterface

/* rtl/core/sqpt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module sqpt_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32,
	parameter int WORDS  = 1024
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [DATA_W-1:0] wd,
	input  logic              re,
	input  logic [ADDR_W-1:0] ra,
	output logic [DATA_W-1:0] rd
);
	logic [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd <= mem[ra];
		end
	end
endmodule

/* rtl/core/sqpt_prio.sv */
// Max priority queue model: sorted store walked one entry a cycle for
// insertion and shift-out. Depends on sqpt_pkg and sqpt_ram.
module sqpt_prio
	import sqpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  sqpt_prio_req_t     req,
	input  logic signed [31:0] value,
	output sqpt_prio_sts_t     sts
);
	localparam logic [1:0] P_IDLE  = 2'd0;
	localparam logic [1:0] P_PUSH  = 2'd1;
	localparam logic [1:0] P_POP0  = 2'd2;
	localparam logic [1:0] P_SHIFT = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [ADDR_W-1:0]  tag_q;
	logic               pend_q;
	logic               alive_q;
	logic               ovf_q;
	logic signed [31:0] v_q;

	logic              we, re;
	logic [ADDR_W-1:0] wa, ra;
	logic [DATA_W-1:0] wd, rdata;
	logic              gt, mismatch, more;

	assign gt       = v_q > $signed(rdata);
	assign mismatch = rdata != v_q;
	assign more     = rd_q < cnt_q;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = v_q;
		re = 1'b0;
		ra = '0;
		unique case (state_q)
			P_PUSH: begin
				if (pend_q) begin
					we = 1'b1;
					wa = pos_q;
					if (gt) begin
						wd = rdata;
						if (pos_q > ADDR_W'(1)) begin
							re = 1'b1;
							ra = pos_q - ADDR_W'(1) - ADDR_W'(1);
						end
					end
				end else if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					re = 1'b1;
					ra = pos_q - ADDR_W'(1);
				end
			end
			P_POP0: begin
				re = 1'b1;
			end
			P_SHIFT: begin
				if (pend_q && tag_q != '0) begin
					we = 1'b1;
					wa = tag_q - ADDR_W'(1);
					wd = rdata;
				end
				if (!(pend_q && tag_q == '0 && mismatch) && more) begin
					re = 1'b1;
					ra = rd_q[ADDR_W-1:0];
				end
			end
			default: ;
		endcase
	end

	sqpt_ram #(.ADDR_W(ADDR_W), .DATA_W(DATA_W), .WORDS(DEPTH)) u_store (
		.clk (clk),
		.we  (we),
		.wa  (wa),
		.wd  (wd),
		.re  (re),
		.ra  (ra),
		.rd  (rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && req.start) begin
			v_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			cnt_q   <= '0;
			rd_q    <= '0;
			pos_q   <= '0;
			tag_q   <= '0;
			pend_q  <= 1'b0;
			alive_q <= 1'b1;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				P_IDLE: begin
					if (req.clear) begin
						cnt_q   <= '0;
						alive_q <= 1'b1;
						ovf_q   <= 1'b0;
					end else if (req.start && alive_q) begin
						if (req.func == FUNC_PUSH) begin
							if (cnt_q >= DEPTH_C) begin
								ovf_q <= 1'b1;
							end else begin
								pos_q   <= cnt_q[ADDR_W-1:0];
								pend_q  <= 1'b0;
								state_q <= P_PUSH;
							end
						end else if (cnt_q == '0) begin
							alive_q <= 1'b0;
						end else begin
							state_q <= P_POP0;
						end
					end
				end
				P_PUSH: begin
					if (pend_q) begin
						if (gt) begin
							pos_q  <= pos_q - ADDR_W'(1);
							pend_q <= pos_q > ADDR_W'(1);
						end else begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= P_IDLE;
						end
					end else if (pos_q == '0) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= P_IDLE;
					end else begin
						pend_q <= 1'b1;
					end
				end
				P_POP0: begin
					pend_q  <= 1'b1;
					tag_q   <= '0;
					rd_q    <= CNT_W'(1);
					state_q <= P_SHIFT;
				end
				P_SHIFT: begin
					if (pend_q && tag_q == '0 && mismatch) begin
						alive_q <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= P_IDLE;
					end else if (more) begin
						pend_q <= 1'b1;
						tag_q  <= rd_q[ADDR_W-1:0];
						rd_q   <= rd_q + CNT_W'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= P_IDLE;
						end
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign sts.busy  = state_q != P_IDLE;
	assign sts.alive = alive_q;
	assign sts.ovf   = ovf_q;
endmodule

/* rtl/core/stack_queue_prio_trace_checker_unit.sv */
// Pacing: each item waits until the priority store walk is done; the walk reads and
//   moves one entry a cycle through the one read port and one write port of its RAM.
// Throughput: a new item is not taken before the last one is through; the next item is taken
//   once the result is in the output register, even while that result still waits to be taken.
// Reset: counts, FIFO head and overflow clear, all three models start alive; the
//   stores are not cleared, no clearing pass runs, so the block is ready right away.
module stack_queue_prio_trace_checker_unit
	import sqpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sqpt_cmd_if.sink   cmd,
	sqpt_res_if.source res
);
	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OP   = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]         state_q;
	logic               func_q;
	logic signed [31:0] val_q;

	// stack and FIFO bookkeeping
	logic [CNT_W-1:0]  scnt_q;
	logic [CNT_W-1:0]  fcnt_q;
	logic [ADDR_W-1:0] head_q;
	logic              s_alive_q;
	logic              q_alive_q;
	logic              ovf_q;

	// output register
	logic       out_valid_q;
	logic       stack_ok_q, queue_ok_q, prio_ok_q, overflow_q;
	logic [2:0] verdict_q;

	sqpt_prio_req_t preq;
	sqpt_prio_sts_t psts;

	logic              s_we, s_re, f_we, f_re;
	logic [ADDR_W-1:0] s_wa, s_ra, f_wa, head_nx;
	logic [CNT_W-1:0]  tail_sum;
	logic [DATA_W-1:0] s_rdata, f_rdata;
	logic              clear;
	logic              load_out;
	logic [2:0]        verdict;

	assign cmd.ready = state_q == ST_IDLE;
	assign clear     = cmd.valid && cmd.ready && cmd.first;
	assign load_out  = state_q == ST_OUT && (!out_valid_q || res.ready);

	// tail slot of the ring: head + count, wrapped with one compare and subtract
	assign tail_sum = CNT_W'(head_q) + fcnt_q;
	assign f_wa     = (tail_sum >= DEPTH_C) ? ADDR_W'(tail_sum - DEPTH_C)
		: tail_sum[ADDR_W-1:0];
	assign head_nx  = (head_q == LAST_C) ? '0 : head_q + ADDR_W'(1);

	// push writes and pop reads are all issued in the op cycle
	always_comb begin
		s_wa = scnt_q[ADDR_W-1:0];
		s_ra = ADDR_W'(scnt_q - CNT_W'(1));
		s_we = state_q == ST_OP && func_q == FUNC_PUSH && s_alive_q && scnt_q < DEPTH_C;
		f_we = state_q == ST_OP && func_q == FUNC_PUSH && q_alive_q && fcnt_q < DEPTH_C;
		s_re = state_q == ST_OP && func_q == FUNC_POP && scnt_q != '0;
		f_re = state_q == ST_OP && func_q == FUNC_POP && fcnt_q != '0;
	end

	sqpt_ram #(.ADDR_W(ADDR_W), .DATA_W(DATA_W), .WORDS(DEPTH)) u_stack (
		.clk (clk),
		.we  (s_we),
		.wa  (s_wa),
		.wd  (val_q),
		.re  (s_re),
		.ra  (s_ra),
		.rd  (s_rdata)
	);

	sqpt_ram #(.ADDR_W(ADDR_W), .DATA_W(DATA_W), .WORDS(DEPTH)) u_fifo (
		.clk (clk),
		.we  (f_we),
		.wa  (f_wa),
		.wd  (val_q),
		.re  (f_re),
		.ra  (head_q),
		.rd  (f_rdata)
	);

	// priority model: cleared with the item, started in the op cycle
	assign preq.clear = clear;
	assign preq.start = state_q == ST_OP;
	assign preq.func  = func_q;

	sqpt_prio u_prio (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.value  (val_q),
		.sts    (psts)
	);

	// verdict from the three alive flags
	always_comb begin
		unique case ({psts.alive, q_alive_q, s_alive_q})
			3'b001:  verdict = VERD_STACK;
			3'b010:  verdict = VERD_QUEUE;
			3'b100:  verdict = VERD_PRIO;
			3'b000:  verdict = VERD_NONE;
			default: verdict = VERD_UNSURE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_q <= cmd.func;
			val_q  <= cmd.value;
		end
		if (load_out) begin
			stack_ok_q <= s_alive_q;
			queue_ok_q <= q_alive_q;
			prio_ok_q  <= psts.alive;
			verdict_q  <= verdict;
			overflow_q <= ovf_q || psts.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scnt_q      <= '0;
			fcnt_q      <= '0;
			head_q      <= '0;
			s_alive_q   <= 1'b1;
			q_alive_q   <= 1'b1;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on a load, drop it once the result is taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						if (cmd.first) begin
							scnt_q    <= '0;
							fcnt_q    <= '0;
							head_q    <= '0;
							s_alive_q <= 1'b1;
							q_alive_q <= 1'b1;
							ovf_q     <= 1'b0;
						end
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					// push: advance counts, flag a full live store
					if (func_q == FUNC_PUSH) begin
						if (s_alive_q) begin
							if (scnt_q >= DEPTH_C) begin
								ovf_q <= 1'b1;
							end else begin
								scnt_q <= scnt_q + CNT_W'(1);
							end
						end
						if (q_alive_q) begin
							if (fcnt_q >= DEPTH_C) begin
								ovf_q <= 1'b1;
							end else begin
								fcnt_q <= fcnt_q + CNT_W'(1);
							end
						end
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// pop: read data is back, kill a model that disagrees
					if (func_q == FUNC_POP) begin
						if (s_alive_q) begin
							if (scnt_q == '0 || s_rdata != val_q) begin
								s_alive_q <= 1'b0;
							end else begin
								scnt_q <= scnt_q - CNT_W'(1);
							end
						end
						if (q_alive_q) begin
							if (fcnt_q == '0 || f_rdata != val_q) begin
								q_alive_q <= 1'b0;
							end else begin
								head_q <= head_nx;
								fcnt_q <= fcnt_q - CNT_W'(1);
							end
						end
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!psts.busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid    = out_valid_q;
	assign res.stack_ok = stack_ok_q;
	assign res.queue_ok = queue_ok_q;
	assign res.prio_ok  = prio_ok_q;
	assign res.verdict  = verdict_q;
	assign res.overflow = overflow_q;

`ifndef SYNTHESIS
	a_ready_prio_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !psts.busy)
		else $error("item taken while the priority walk is still running");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		scnt_q <= DEPTH_C && fcnt_q <= DEPTH_C)
		else $error("stack or FIFO count beyond depth");

	a_stack_stays_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_alive_q && !clear) |=> !s_alive_q)
		else $error("dead stack model came back without a clear");

	a_prio_stays_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(!psts.alive && !clear) |=> !psts.alive)
		else $error("dead priority model came back without a clear");
`endif
endmodule
